// ===== hw/rtl/tli_pkg.sv =====
// Shared constants and controller/datapath interface types for the table interpolator.
package tli_pkg;

  localparam int TableDepthDefault = 256;
  localparam int CfgWidth          = 9;
  localparam int DivSteps          = 32;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_TABLE_ERR = 2'd1;
  localparam logic [1:0] STATUS_SAT       = 2'd2;

  typedef struct packed {
    logic load_wr;
    logic start;
    logic sweep_run;
    logic srch_rd;
    logic srch_upd;
    logic rd_lo;
    logic rd_hi;
    logic lat_lo;
    logic lat_hi;
    logic mul_a;
    logic mul_b;
    logic sum;
    logic abs_val;
    logic prep;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic err;
    logic srch_done;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

// ===== hw/rtl/tli_ctrl.sv =====
// Sequencing state machine for the table interpolator.
module tli_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          req_type_i,
  output logic          in_ready_o,
  input  tli_pkg::stat_t stat_i,
  output tli_pkg::cmd_t  cmd_o
);

  typedef enum logic [13:0] {
    ST_IDLE     = 14'b00000000000001,
    ST_SWEEP    = 14'b00000000000010,
    ST_SRCH_CHK = 14'b00000000000100,
    ST_SRCH_CMP = 14'b00000000001000,
    ST_F_LO     = 14'b00000000010000,
    ST_F_HI     = 14'b00000000100000,
    ST_LAT_HI   = 14'b00000001000000,
    ST_MUL_A    = 14'b00000010000000,
    ST_MUL_B    = 14'b00000100000000,
    ST_SUM      = 14'b00001000000000,
    ST_ABS      = 14'b00010000000000,
    ST_PREP     = 14'b00100000000000,
    ST_DIV      = 14'b01000000000000,
    ST_FIN      = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == tli_pkg::REQ_QUERY) begin
            cmd_o.start = 1'b1;
            state_d     = ST_SWEEP;
          end else begin
            cmd_o.load_wr = 1'b1;
          end
        end
      end
      ST_SWEEP: begin
        cmd_o.sweep_run = 1'b1;
        if (stat_i.sweep_done) state_d = ST_SRCH_CHK;
      end
      ST_SRCH_CHK: begin
        if (stat_i.err) begin
          state_d = ST_FIN;
        end else if (stat_i.srch_done) begin
          state_d = ST_F_LO;
        end else begin
          cmd_o.srch_rd = 1'b1;
          state_d       = ST_SRCH_CMP;
        end
      end
      ST_SRCH_CMP: begin
        cmd_o.srch_upd = 1'b1;
        state_d        = ST_SRCH_CHK;
      end
      ST_F_LO: begin
        cmd_o.rd_lo = 1'b1;
        state_d     = ST_F_HI;
      end
      ST_F_HI: begin
        cmd_o.rd_hi  = 1'b1;
        cmd_o.lat_lo = 1'b1;
        state_d      = ST_LAT_HI;
      end
      ST_LAT_HI: begin
        cmd_o.lat_hi = 1'b1;
        state_d      = ST_MUL_A;
      end
      ST_MUL_A: begin
        cmd_o.mul_a = 1'b1;
        state_d     = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd_o.mul_b = 1'b1;
        state_d     = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_ABS;
      end
      ST_ABS: begin
        cmd_o.abs_val = 1'b1;
        state_d       = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_done) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/tli_dp.sv =====
// Datapath: breakpoint memories, monotonic sweep, search, multiply and serial divide.
module tli_dp #(
  parameter int TableDepth = tli_pkg::TableDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tli_pkg::CfgWidth-1:0]  cfg_wdata_i,
  input  logic [7:0]                    entry_index_i,
  input  logic signed [31:0]            entry_x_i,
  input  logic signed [31:0]            entry_y_i,
  input  logic signed [31:0]            query_x_i,
  input  tli_pkg::cmd_t                 cmd_i,
  output tli_pkg::stat_t                stat_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic signed [31:0]            result_y_o,
  output logic [1:0]                    status_o
);

  localparam int AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CW = AW + 1;
  localparam int EW = (CW > tli_pkg::CfgWidth) ? CW : tli_pkg::CfgWidth;

  logic [31:0] mem_x [TableDepth];
  logic [31:0] mem_y [TableDepth];

  logic [tli_pkg::CfgWidth-1:0] pc_q;
  logic [EW-1:0] pc_ext, idx_ext, n_ext;
  logic [CW-1:0] n_eff, n_eff_m1, n_q, n_q_m1;
  logic [AW-1:0] wr_addr, rd_addr;
  logic signed [31:0] rdx_q, rdy_q;

  logic signed [31:0] q_q, prev_q, xl_q, yl_q, xh_q, yh_q;
  logic [CW-1:0] sw_cnt_q;
  logic          sw_dv_q;
  logic [AW-1:0] sw_di_q;
  logic          sw_last, sw_issue;
  logic          up_q, err_q;

  logic [AW-1:0] lo_q, hi_q, mid, span;
  logic [AW:0]   mid_sum;
  logic          go_lo;

  logic signed [32:0] ma;
  logic signed [31:0] mb;
  logic signed [64:0] p1_q, p2_q, prod;
  logic signed [65:0] num_q;
  logic signed [32:0] den_q;
  logic [63:0]   nmag_q;
  logic [31:0]   dmag_q;
  logic          neg_q, big_q, dz_q;
  logic [31:0]   rem_q, quo_q;
  logic [32:0]   r2;
  logic          ge;
  logic [4:0]    div_cnt_q;

  logic signed [31:0] res_d;
  logic [1:0]         st_d;
  logic               out_valid_q;

  // Point count clamped to the table size.
  assign pc_ext  = EW'(pc_q);
  assign idx_ext = EW'(entry_index_i);
  assign n_ext   = (pc_ext < EW'(2)) ? EW'(2) :
                   (pc_ext > EW'(TableDepth)) ? EW'(TableDepth) : pc_ext;
  assign n_eff    = n_ext[CW-1:0];
  assign n_eff_m1 = n_eff - CW'(1);
  assign n_q_m1   = n_q - CW'(1);
  assign wr_addr  = idx_ext[AW-1:0];

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[AW:1];
  assign span    = hi_q - lo_q;

  assign sw_issue = cmd_i.sweep_run && (sw_cnt_q != n_q);
  assign sw_last  = sw_dv_q && (CW'(sw_di_q) == n_q_m1);

  always_comb begin
    if (cmd_i.srch_rd)    rd_addr = mid;
    else if (cmd_i.rd_lo) rd_addr = lo_q;
    else if (cmd_i.rd_hi) rd_addr = hi_q;
    else                  rd_addr = sw_cnt_q[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && (idx_ext < EW'(TableDepth))) begin
      mem_x[wr_addr] <= entry_x_i;
      mem_y[wr_addr] <= entry_y_i;
    end
    rdx_q <= mem_x[rd_addr];
    rdy_q <= mem_y[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= tli_pkg::CfgWidth'(2);
    end else if (cfg_we_i) begin
      pc_q <= cfg_wdata_i;
    end
  end

  // Monotonic sweep and search
  assign go_lo = up_q ? (q_q > rdx_q) : (q_q < rdx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_cnt_q <= '0;
      sw_dv_q  <= 1'b0;
      err_q    <= 1'b0;
    end else if (cmd_i.start) begin
      sw_cnt_q <= '0;
      sw_dv_q  <= 1'b0;
      err_q    <= 1'b0;
    end else begin
      sw_dv_q <= sw_issue;
      if (sw_issue) sw_cnt_q <= sw_cnt_q + CW'(1);
      if (sw_dv_q) begin
        if (sw_di_q == AW'(1)) begin
          if (rdx_q == prev_q) err_q <= 1'b1;
        end else if (sw_di_q != '0) begin
          if (up_q ? (rdx_q <= prev_q) : (rdx_q >= prev_q)) err_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      q_q  <= query_x_i;
      n_q  <= n_eff;
      lo_q <= '0;
      hi_q <= n_eff_m1[AW-1:0];
    end
    sw_di_q <= sw_cnt_q[AW-1:0];
    if (sw_dv_q) begin
      prev_q <= rdx_q;
      if (sw_di_q == AW'(1)) up_q <= (rdx_q > prev_q);
    end
    if (cmd_i.srch_upd) begin
      if (go_lo) lo_q <= mid;
      else       hi_q <= mid;
    end
    if (cmd_i.lat_lo) begin
      xl_q <= rdx_q;
      yl_q <= rdy_q;
    end
    if (cmd_i.lat_hi) begin
      xh_q <= rdx_q;
      yh_q <= rdy_q;
    end
  end

  // One shared multiplier for both cross products
  assign ma   = cmd_i.mul_a ? (33'(xh_q) - 33'(q_q)) : (33'(q_q) - 33'(xl_q));
  assign mb   = cmd_i.mul_a ? yl_q : yh_q;
  assign prod = ma * 65'(mb);

  assign r2 = {rem_q, quo_q[31]};
  assign ge = (r2 >= {1'b0, dmag_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_a) p1_q <= prod;
    if (cmd_i.mul_b) p2_q <= prod;
    if (cmd_i.sum) begin
      num_q <= 66'(p1_q) + 66'(p2_q);
      den_q <= 33'(xh_q) - 33'(xl_q);
    end
    if (cmd_i.abs_val) begin
      nmag_q <= num_q[65] ? 64'(-num_q) : num_q[63:0];
      dmag_q <= den_q[32] ? 32'(-den_q) : den_q[31:0];
      neg_q  <= num_q[65] ^ den_q[32];
    end
    if (cmd_i.prep) begin
      // quotient of 2^32 or more always saturates
      big_q <= (nmag_q[63:32] >= dmag_q);
      dz_q  <= (dmag_q == '0);
      rem_q <= nmag_q[63:32];
      quo_q <= nmag_q[31:0];
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? 32'(r2 - {1'b0, dmag_q}) : r2[31:0];
      quo_q <= {quo_q[30:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.prep) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + 5'd1;
    end
  end

  always_comb begin
    res_d = '0;
    st_d  = tli_pkg::STATUS_OK;
    if (err_q || dz_q) begin
      st_d = tli_pkg::STATUS_TABLE_ERR;
    end else if (big_q) begin
      st_d  = tli_pkg::STATUS_SAT;
      res_d = neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (neg_q && (quo_q != '0)) begin
      if (quo_q > 32'h8000_0000) begin
        st_d  = tli_pkg::STATUS_SAT;
        res_d = 32'sh8000_0000;
      end else begin
        res_d = -$signed(quo_q);
      end
    end else if (quo_q > 32'h7FFF_FFFF) begin
      st_d  = tli_pkg::STATUS_SAT;
      res_d = 32'sh7FFF_FFFF;
    end else begin
      res_d = $signed(quo_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      result_y_o <= res_d;
      status_o   <= st_d;
    end
  end

  assign out_valid_o = out_valid_q;

  assign stat_o.sweep_done = sw_last;
  assign stat_o.err        = err_q;
  assign stat_o.srch_done  = (span <= AW'(1));
  assign stat_o.div_done   = (div_cnt_q == 5'(tli_pkg::DivSteps - 1));
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

endmodule

// ===== hw/rtl/table_linear_interpolator.sv =====
// Top level of the piecewise linear table interpolator.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-----------------------------------------
//  in       | in_valid_i / in_ready_o      | req_type, entry_index, entry_x/y, query_x
//  out      | out_valid_o / out_ready_i    | result_y, status
//  cfg      | cfg_we_i                     | cfg_wdata_i (point_count)
//
// A load beat is written as it is accepted, and the block stays ready. A query over n
// breakpoints runs a monotonic sweep reading one entry per cycle from the single read
// port, a binary search that alternates read and compare, the fetch, multiply and sign
// handling steps, then a 32-step serial divide; a table error skips to the result.
// Reset sets point_count to 2; the table holds no reset value.
// A finished result sits in the output register; a new beat is taken meanwhile, and
// the next query stalls at its end only if that register is still occupied.
module table_linear_interpolator #(
  parameter int TableDepth = tli_pkg::TableDepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tli_pkg::CfgWidth-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         req_type_i,
  input  logic [7:0]                   entry_index_i,
  input  logic signed [31:0]           entry_x_i,
  input  logic signed [31:0]           entry_y_i,
  input  logic signed [31:0]           query_x_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [31:0]           result_y_o,
  output logic [1:0]                   status_o
);

  tli_pkg::cmd_t  cmd;
  tli_pkg::stat_t stat;

  tli_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tli_dp #(
    .TableDepth (TableDepth)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .entry_index_i (entry_index_i),
    .entry_x_i     (entry_x_i),
    .entry_y_i     (entry_y_i),
    .query_x_i     (query_x_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .result_y_o    (result_y_o),
    .status_o      (status_o)
  );

endmodule

// ===== test/tb_table_linear_interpolator.sv =====
// Self-checking testbench for the piecewise linear table interpolator.
`timescale 1ns / 100ps

module tb_table_linear_interpolator;

  localparam int Depth      = 256;
  localparam int CycleLimit = 4000000;
  localparam int RandItems  = 1090;

  typedef struct {
    logic               req;
    logic [7:0]         idx;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] qx;
  } beat_t;

  typedef struct {
    logic signed [31:0] y;
    logic [1:0]         st;
  } interp_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [tli_pkg::CfgWidth-1:0] cfg_wdata_i;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic                         req_type_i;
  logic [7:0]                   entry_index_i;
  logic signed [31:0]           entry_x_i;
  logic signed [31:0]           entry_y_i;
  logic signed [31:0]           query_x_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic signed [31:0]           result_y_o;
  logic [1:0]                   status_o;

  table_linear_interpolator uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .req_type_i, .entry_index_i, .entry_x_i, .entry_y_i, .query_x_i,
    .out_valid_o, .out_ready_i, .result_y_o, .status_o
  );

  // predictor state
  logic signed [31:0] bp_x [Depth];
  logic signed [31:0] bp_y [Depth];
  int unsigned        count_reg;

  beat_t   pending_beats[$];
  interp_t expected_interp[$];
  int      mismatches;
  int      loads_sent, queries_sent, sat_seen, err_seen, results_seen;
  int      cycles;

  // stimulus-side shadow of the table being built
  logic signed [31:0] gen_x [Depth];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic interp_t interpolate(input logic signed [31:0] q);
    interp_t r;
    int unsigned n, lo, hi, mid;
    bit up;
    logic signed [127:0] xl, xh, yl, yh, qq, num, den, quo;
    r.y = '0;
    r.st = tli_pkg::STATUS_TABLE_ERR;
    n = count_reg < 2 ? 2 : (count_reg > Depth ? Depth : count_reg);
    if (bp_x[1] > bp_x[0]) up = 1'b1;
    else if (bp_x[1] < bp_x[0]) up = 1'b0;
    else return r;
    for (int i = 1; i + 1 < n; i++)
      if (up ? (bp_x[i+1] <= bp_x[i]) : (bp_x[i+1] >= bp_x[i])) return r;
    lo = 0;
    hi = n - 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (up ? (q > bp_x[mid]) : (q < bp_x[mid])) lo = mid;
      else hi = mid;
    end
    xl = bp_x[lo];
    xh = bp_x[hi];
    yl = bp_y[lo];
    yh = bp_y[hi];
    qq = q;
    num = (xh - qq) * yl + (qq - xl) * yh;
    den = xh - xl;
    quo = num / den;  // truncates toward zero
    r.st = tli_pkg::STATUS_OK;
    if (quo > 128'sd2147483647) begin
      quo = 128'sd2147483647;
      r.st = tli_pkg::STATUS_SAT;
    end else if (quo < -128'sd2147483648) begin
      quo = -128'sd2147483648;
      r.st = tli_pkg::STATUS_SAT;
    end
    r.y = quo[31:0];
    return r;
  endfunction

  // sender: bursts with random gaps
  beat_t cur_beat;
  int    burst_left, gap_left;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        if (cur_beat.req == tli_pkg::REQ_LOAD) begin
          bp_x[cur_beat.idx] = cur_beat.ex;
          bp_y[cur_beat.idx] = cur_beat.ey;
        end else begin
          expected_interp.push_back(interpolate(cur_beat.qx));
        end
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          cur_beat = pending_beats.pop_front();
          in_valid_i    <= 1'b1;
          req_type_i    <= cur_beat.req;
          entry_index_i <= cur_beat.idx;
          entry_x_i     <= cur_beat.ex;
          entry_y_i     <= cur_beat.ey;
          query_x_i     <= cur_beat.qx;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: random stall modes, from always ready to a long stall
  int stall_mode, stall_left;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_mode = 0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_interp.size() == 0) begin
          $display("%0t: unexpected result y=%h status=%0d", $time, result_y_o, status_o);
          mismatches++;
        end else begin
          interp_t e;
          e = expected_interp.pop_front();
          if (e.y !== result_y_o) begin
            $display("%0t: result_y expected %h actual %h", $time, e.y, result_y_o);
            mismatches++;
          end
          if (e.st !== status_o) begin
            $display("%0t: status expected %0d actual %0d", $time, e.st, status_o);
            mismatches++;
          end
          if (e.st == tli_pkg::STATUS_SAT) sat_seen++;
          if (e.st == tli_pkg::STATUS_TABLE_ERR) err_seen++;
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 3) != 0);
        2: out_ready_i <= ($urandom_range(0, 7) == 0);
        default: out_ready_i <= 1'b0;  // long stall
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic push_load(input int idx, input logic signed [31:0] x,
                           input logic signed [31:0] y);
    beat_t b;
    b.req = tli_pkg::REQ_LOAD;
    b.idx = 8'(idx);
    b.ex  = x;
    b.ey  = y;
    b.qx  = $urandom();
    pending_beats.push_back(b);
    loads_sent++;
  endtask

  task automatic push_query(input logic signed [31:0] q);
    beat_t b;
    b.req = tli_pkg::REQ_QUERY;
    b.idx = 8'($urandom());
    b.ex  = $urandom();
    b.ey  = $urandom();
    b.qx  = q;
    pending_beats.push_back(b);
    queries_sent++;
  endtask

  // sample after the edge so driver updates have settled
  task automatic wait_idle();
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_beats.size() > 0 || in_valid_i || expected_interp.size() > 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_count(input int unsigned v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v[tli_pkg::CfgWidth-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= tli_pkg::CfgWidth'($urandom());
    count_reg = v & 32'h1FF;
  endtask

  function automatic logic signed [31:0] pick_y();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 2000)) - 1000;
      default: return $urandom();
    endcase
  endfunction

  // kind: 0 increasing, 1 decreasing, 2 broken order, 3 equal first abscissae
  task automatic build_table(input int n, input int kind);
    longint unsigned steps_sum, step_max, s, slack;
    longint x0;
    longint acc [Depth];
    int j;
    step_max = ($urandom_range(0, 2) == 0) ? 64'd16 : (64'd4294967295 / n);
    steps_sum = 0;
    acc[0] = 0;
    for (int i = 1; i < n; i++) begin
      s = ($urandom_range(0, 7) == 0) ? 1 : {$urandom()} % step_max + 1;
      steps_sum += s;
      acc[i] = steps_sum;
    end
    slack = 64'd4294967295 - steps_sum;
    x0 = -64'sd2147483648 + longint'({$urandom()} % (slack + 1));
    for (int i = 0; i < n; i++)
      gen_x[(kind == 1) ? n - 1 - i : i] = 32'(x0 + acc[i]);
    if (kind == 2) begin
      j = $urandom_range(1, n - 1);
      gen_x[j] = gen_x[j - 1];
    end else if (kind == 3) begin
      gen_x[1] = gen_x[0];
    end
    for (int i = 0; i < n; i++) push_load(i, gen_x[i], pick_y());
  endtask

  function automatic logic signed [31:0] pick_query(input int n);
    int k;
    k = $urandom_range(0, n - 1);
    case ($urandom_range(0, 6))
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2: return gen_x[k];
      3: return gen_x[k] + $signed($urandom_range(0, 2)) - 1;
      4: return (k + 1 < n) ? gen_x[k] + (gen_x[k+1] - gen_x[k]) / 2 : gen_x[k];
      default: return $urandom();
    endcase
  endfunction

  task automatic query_phase(input int n, input int nq);
    for (int i = 0; i < nq; i++) begin
      if ($urandom_range(0, 19) == 0) push_load($urandom_range(0, Depth - 1),
                                                $urandom(), pick_y());
      else push_query(pick_query(n));
    end
  endtask

  initial begin
    int n, kind, start_items;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    req_type_i    = tli_pkg::REQ_LOAD;
    entry_index_i = '0;
    entry_x_i     = '0;
    entry_y_i     = '0;
    query_x_i     = '0;
    out_ready_i   = 1'b0;
    count_reg     = 2;
    mismatches    = 0;
    cycles        = 0;
    for (int i = 0; i < Depth; i++) begin
      bp_x[i] = '0;
      bp_y[i] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: two-point table at reset count, extremes, saturation, errors
    push_load(0, 32'sh0, 32'sh0);
    push_load(1, 32'sh10000, 32'sh7fffffff);
    push_query(32'sh0);
    push_query(32'sh10000);
    push_query(32'sh8000);
    push_query(32'sh7fffffff);
    push_query(32'sh80000000);
    push_query(-32'sh10000);
    push_load(1, 32'sh0, 32'sh1234);  // equal first abscissae
    push_query(32'sh5);
    push_load(0, 32'sh7fffffff, 32'sh80000000);
    push_load(1, 32'sh80000000, 32'sh7fffffff);  // decreasing, full span
    push_query(32'sh0);
    push_query(32'sh80000000);
    push_query(32'sh7fffffff);
    wait_idle();
    write_count(0);  // clamps to two
    push_query(32'sh100);
    wait_idle();
    write_count(1);
    push_query(-32'sh100);
    wait_idle();

    // full table, counts at and above the depth
    for (int r = 0; r < 3; r++) begin
      write_count(r == 0 ? 256 : (r == 1 ? 511 : 300));
      build_table(Depth, r);
      query_phase(Depth, 25);
      wait_idle();
    end

    start_items = loads_sent + queries_sent;
    while (loads_sent + queries_sent - start_items < RandItems) begin
      case ($urandom_range(0, 9))
        0: n = $urandom_range(13, 48);
        1: n = 2;
        default: n = $urandom_range(3, 12);
      endcase
      kind = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 1) : $urandom_range(2, 3);
      if (kind == 2 && n < 2) kind = 0;
      write_count(n);
      build_table(n, kind);
      query_phase(n, $urandom_range(10, 50));
      wait_idle();
    end

    $display("covered %0d loads and %0d queries, %0d results checked", loads_sent,
             queries_sent, results_seen);
    $display("table errors seen %0d, saturated results %0d", err_seen, sat_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
